// File: sv/rle_sprite_palette_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RLE sprite palette decoder
// Clocked concurrent checks, reset-qualified or not; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef RLE_SPRITE_PALETTE_DECODER_CORE_DEFINES_SVH
`define RLE_SPRITE_PALETTE_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that holds once reset is released.
`define RSPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that holds at every edge, reset included.
`define RSPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RSPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/rspd_pkg.sv
// ----------------------------------------------------------------------------
// rspd_pkg
// Shared types and constants of the RLE sprite palette decoder.
// ----------------------------------------------------------------------------
package rspd_pkg;

    localparam int MAX_SIDE_DEFAULT = 2048;
    localparam int PALETTE_DEPTH    = 256;
    localparam int PAL_AW           = $clog2(PALETTE_DEPTH);
    localparam int COLOR_W          = 24;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 12;
    localparam int CFG_DIM_RESET    = 64;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // input action codes
    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_SPRITE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE     = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [10:0] run_x;
        logic [10:0] run_y;
        logic [7:0]  run_length;
        logic [31:0] pixel_color;
        logic        is_transparent;
        logic        row_done;
        logic        frame_done;
    } t_out_item;

    // run description from the decoder, color still to come from the palette
    typedef struct packed {
        logic [10:0] run_x;
        logic [10:0] run_y;
        logic [7:0]  run_length;
        logic        is_transparent;
        logic        row_done;
        logic        frame_done;
    } t_run_meta;

endpackage

// File: sv/rspd_palette_ram.sv
// ----------------------------------------------------------------------------
// rspd_palette_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rspd_palette_ram (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [rspd_pkg::PAL_AW-1:0]         i_waddr,
    input  logic [rspd_pkg::COLOR_W-1:0]        i_wdata,
    input  logic                                i_re,
    input  logic [rspd_pkg::PAL_AW-1:0]         i_raddr,
    output logic [rspd_pkg::COLOR_W-1:0]        o_rdata
);
    import rspd_pkg::*;

    logic [COLOR_W-1:0] r_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/rspd_decode.sv
// ----------------------------------------------------------------------------
// rspd_decode
// Row-record / plain byte decoder: walks the record phases, tracks column,
// row and remaining record bytes, and issues palette accesses.
// ----------------------------------------------------------------------------
`include "rle_sprite_palette_decoder_core_defines.svh"

module rspd_decode #(
    parameter int MAX_SIDE = rspd_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_restart,
    input  logic [$clog2(MAX_SIDE+1)-1:0]       i_width,
    input  logic [$clog2(MAX_SIDE+1)-1:0]       i_height,
    input  logic                                i_rle,
    input  logic                                i_take,
    input  rspd_pkg::t_in_item                  i_item,
    output logic                                o_emit,
    output rspd_pkg::t_run_meta                 o_meta,
    output logic                                o_rd_en,
    output logic [rspd_pkg::PAL_AW-1:0]         o_rd_addr,
    output logic                                o_wr_en,
    output logic [rspd_pkg::PAL_AW-1:0]         o_wr_addr,
    output logic [rspd_pkg::COLOR_W-1:0]        o_wr_data
);
    import rspd_pkg::*;

    localparam int SW = $clog2(MAX_SIDE);      // column / row position
    localparam int WW = $clog2(MAX_SIDE + 1);  // holds a full side length

    typedef enum logic [2:0] {
        PH_LEN_LO = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_PIXEL  = 3'd2,
        PH_COUNT  = 3'd3,
        PH_PAD    = 3'd4
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [SW-1:0]  r_col,   n_col;
    logic [SW-1:0]  r_row,   n_row;
    logic [15:0]    r_left,  n_left;
    logic [7:0]     r_len_lo, n_len_lo;

    logic [7:0]     b;
    logic [15:0]    left_dec;
    logic [15:0]    rec_len;
    logic [WW-1:0]  room;
    logic [7:0]     cnt;
    logic [7:0]     run_len;
    logic [WW-1:0]  col_sum;
    logic           row_end;
    logic           frame_end;
    logic           emit;
    logic           trans;

    assign b        = i_item.data_byte;
    assign left_dec = (r_left != 16'd0) ? r_left - 16'd1 : r_left;
    assign rec_len  = {b, r_len_lo};
    assign room     = i_width - WW'(r_col);
    assign cnt      = (32'(b) > 32'(room)) ? 8'(room) : b;

    always_comb begin
        n_phase  = r_phase;
        n_col    = r_col;
        n_row    = r_row;
        n_left   = r_left;
        n_len_lo = r_len_lo;
        emit     = 1'b0;
        trans    = 1'b0;
        run_len  = 8'd1;

        if (i_take && i_item.action == ACT_SPRITE) begin
            if (!i_rle) begin
                emit  = 1'b1;
                trans = (b == 8'd0);
            end else begin
                unique case (r_phase)
                    PH_LEN_LO: begin
                        n_len_lo = b;
                        n_phase  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_left  = (rec_len >= 16'd2) ? rec_len - 16'd2 : 16'd0;
                        n_phase = PH_PIXEL;
                    end
                    PH_PIXEL: begin
                        n_left = left_dec;
                        if (b == 8'd0) begin
                            n_phase = PH_COUNT;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                    PH_COUNT: begin
                        n_left  = left_dec;
                        n_phase = PH_PIXEL;
                        if (b != 8'd0) begin
                            emit    = 1'b1;
                            trans   = 1'b1;
                            run_len = cnt;
                        end
                    end
                    PH_PAD: begin
                        n_left = left_dec;
                        if (left_dec == 16'd0) begin
                            n_phase = PH_LEN_LO;
                        end
                    end
                    default: begin
                        n_phase = PH_LEN_LO;
                    end
                endcase
            end
        end

        // run never passes the row end, so the sum fits a side length
        col_sum   = WW'(r_col) + WW'(run_len);
        row_end   = (col_sum >= i_width);
        frame_end = (WW'(r_row) + WW'(1) >= i_height);

        if (emit) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + SW'(1);
                if (i_rle) begin
                    n_phase = (n_left != 16'd0) ? PH_PAD : PH_LEN_LO;
                end
            end else begin
                n_col = SW'(col_sum);
            end
        end

        if (i_restart) begin
            n_phase  = PH_LEN_LO;
            n_col    = '0;
            n_row    = '0;
            n_left   = '0;
            n_len_lo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEN_LO;
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
            r_len_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_col    <= n_col;
            r_row    <= n_row;
            r_left   <= n_left;
            r_len_lo <= n_len_lo;
        end
    end

    assign o_emit                = emit;
    assign o_meta.run_x          = 11'(r_col);
    assign o_meta.run_y          = 11'(r_row);
    assign o_meta.run_length     = run_len;
    assign o_meta.is_transparent = trans;
    assign o_meta.row_done       = row_end;
    assign o_meta.frame_done     = row_end && frame_end;

    assign o_rd_en   = emit && !trans;
    assign o_rd_addr = b;
    assign o_wr_en   = i_take && (i_item.action == ACT_PALETTE);
    assign o_wr_addr = i_item.entry_index;
    assign o_wr_data = {i_item.blue, i_item.green, i_item.red};

    `RSPD_ASSERT(a_col_in_row, i_clk, i_rst_n, (WW'(r_col) < i_width), "column past row end")
    `RSPD_ASSERT(a_row_in_frame, i_clk, i_rst_n, (WW'(r_row) < i_height), "row past frame end")
    `RSPD_ASSERT(a_plain_phase_hold, i_clk, i_rst_n, (!i_rle && !i_restart) |=> (r_phase == $past(r_phase)), "phase moved in plain mode")

endmodule

// File: sv/rspd_out_buf.sv
// ----------------------------------------------------------------------------
// rspd_out_buf
// Palette-read stage and output register; merges run info with read color.
// ----------------------------------------------------------------------------
`include "rle_sprite_palette_decoder_core_defines.svh"

module rspd_out_buf (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  rspd_pkg::t_run_meta                 i_meta,
    input  logic [rspd_pkg::COLOR_W-1:0]        i_rdata,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rspd_pkg::t_out_item                 o_out_data
);
    import rspd_pkg::*;

    logic       r_s1_valid;
    t_run_meta  r_s1_meta;
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_out_item  s1_item;
    logic       s1_adv;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_out_valid || i_out_ready;

    always_comb begin
        s1_item.run_x          = r_s1_meta.run_x;
        s1_item.run_y          = r_s1_meta.run_y;
        s1_item.run_length     = r_s1_meta.run_length;
        s1_item.pixel_color    = r_s1_meta.is_transparent ? 32'd0 : {ALPHA_OPAQUE, i_rdata};
        s1_item.is_transparent = r_s1_meta.is_transparent;
        s1_item.row_done       = r_s1_meta.row_done;
        s1_item.frame_done     = r_s1_meta.frame_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_meta <= i_meta;
        end
        if (s1_adv) begin
            r_out_data <= s1_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `RSPD_ASSERT(a_no_overrun, i_clk, i_rst_n, i_load |-> !(r_s1_valid && r_out_valid && !i_out_ready), "run loaded into full stage")
    `RSPD_ASSERT(a_s1_hold, i_clk, i_rst_n, (r_s1_valid && r_out_valid && !i_out_ready) |=> (r_s1_valid && $stable(r_s1_meta)), "stalled run lost")

endmodule

// File: sv/rle_sprite_palette_decoder_core.sv
// ----------------------------------------------------------------------------
// rle_sprite_palette_decoder_core
// Sprite byte decoder with a 256-entry palette, producing pixel runs.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat is either a
// palette write (action 0: entry_index, red, green, blue) or one sprite byte
// (action 1: data_byte). Output channel (o_out_valid / i_out_ready /
// o_out_data): one beat per pixel run, with row and frame end marks.
// Header bytes, the count-awaiting zero byte, zero counts, pad bytes and
// palette writes produce no output beat.
// Config port (i_cfg_we / i_cfg_index / i_cfg_wdata): frame_width,
// frame_height, rle_mode; write only while idle. Any write to a known index
// restarts the frame; the palette is kept.
// Throughput: one input beat per clock while not stalled. All decode state
// updates in the cycle of acceptance, and the palette read is the only memory
// access per byte, so a byte can follow in the very next cycle.
// Path: the edge that takes a byte loads its run into the read stage with the
// palette read; the output register loads from the read stage once it is free.
// Stall: when the output register is full and not taken, one more run parks
// in the read stage; after that o_in_ready drops until the receiver drains.
// Reset: frame state returns to the start of a record, config to 64x64 RLE;
// palette contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module rle_sprite_palette_decoder_core #(
    parameter int MAX_SIDE = rspd_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rspd_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rspd_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [rspd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rspd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import rspd_pkg::*;

    localparam int WW = $clog2(MAX_SIDE + 1);

    // geometry is stored already clamped to 1..MAX_SIDE
    logic [WW-1:0]      r_width;
    logic [WW-1:0]      r_height;
    logic               r_rle;
    logic [WW-1:0]      dim_clamped;
    logic               cfg_restart;

    logic               take;
    logic               emit;
    t_run_meta          meta;
    logic               rd_en;
    logic [PAL_AW-1:0]  rd_addr;
    logic               wr_en;
    logic [PAL_AW-1:0]  wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic [COLOR_W-1:0] rdata;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            dim_clamped = WW'(1);
        end else if (32'(i_cfg_wdata) > MAX_SIDE) begin
            dim_clamped = WW'(MAX_SIDE);
        end else begin
            dim_clamped = WW'(i_cfg_wdata);
        end
    end

    always_comb begin
        cfg_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_RLE_MODE: cfg_restart = 1'b1;
                default:                                         cfg_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(CFG_DIM_RESET);
            r_height <= WW'(CFG_DIM_RESET);
            r_rle    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width  <= dim_clamped;
                CFG_FRAME_HEIGHT: r_height <= dim_clamped;
                CFG_RLE_MODE:     r_rle    <= i_cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    assign take = i_in_valid && o_in_ready;

    rspd_decode #(
        .MAX_SIDE (MAX_SIDE)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_restart),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_rle     (r_rle),
        .i_take    (take),
        .i_item    (i_in_data),
        .o_emit    (emit),
        .o_meta    (meta),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // writes and reads come from distinct beats, so a read always sees
    // a write taken in an earlier cycle
    rspd_palette_ram u_palette (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    rspd_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit),
        .i_meta      (meta),
        .i_rdata     (rdata),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: test/rle_sprite_palette_decoder_core_test.sv
// ----------------------------------------------------------------------------
// rle_sprite_palette_decoder_core_test
// Self-checking bench for the sprite decoder. It streams palette writes and
// sprite bytes, and predicts each pixel run from its own copy of the decode
// state. Runs are compared field by field, in order. Both channels idle at
// random, and the geometry and mode change between phases.
// ----------------------------------------------------------------------------
module rle_sprite_palette_decoder_core_test;
    import rspd_pkg::*;

    // Register index with no register behind it; a write there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Where the decoder stands inside an RLE row record.
    typedef enum logic [2:0] {
        AWAIT_LEN_LO,
        AWAIT_LEN_HI,
        IN_PIXELS,
        AWAIT_COUNT,
        SKIP_PAD
    } t_rec_phase;

    // ------------------------------------------------------------------------
    // Run predictor and the queue of runs still owed by the block.
    // ------------------------------------------------------------------------
    class t_run_scoreboard;
        logic [11:0] width_reg;
        logic [11:0] height_reg;
        bit          rle_on;
        t_rec_phase  ph;
        int unsigned col;
        int unsigned row;
        int unsigned bytes_left;
        logic [7:0]  len_lo;
        logic [23:0] palette [PALETTE_DEPTH];
        bit          written [PALETTE_DEPTH];
        t_out_item   runs_due [$];
        int unsigned beats;
        int unsigned pal_writes;
        int unsigned runs_seen;
        int unsigned frames;
        int unsigned errors;

        function new();
            width_reg  = 12'(CFG_DIM_RESET);
            height_reg = 12'(CFG_DIM_RESET);
            rle_on     = 1'b1;
            restart();
        endfunction

        function void restart();
            ph         = AWAIT_LEN_LO;
            col        = 0;
            row        = 0;
            bytes_left = 0;
            len_lo     = 8'd0;
        endfunction

        function int unsigned eff_side(logic [11:0] v);
            if (v == 12'd0) return 1;
            if (v > MAX_SIDE_DEFAULT) return MAX_SIDE_DEFAULT;
            return v;
        endfunction

        // True when this sprite byte, taken now, would look up the palette.
        function bit reads_palette(logic [7:0] b);
            return b != 8'd0 && (!rle_on || ph == IN_PIXELS);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg  = val;
                CFG_FRAME_HEIGHT: height_reg = val;
                CFG_RLE_MODE:     rle_on     = val[0];
                default:          return;
            endcase
            restart();
        endfunction

        function void add_run(int unsigned len, logic [31:0] color, bit clear);
            t_out_item r;
            r.run_x          = 11'(col);
            r.run_y          = 11'(row);
            r.run_length     = 8'(len);
            r.pixel_color    = clear ? 32'd0 : color;
            r.is_transparent = clear;
            r.row_done       = 1'b0;
            r.frame_done     = 1'b0;
            col += len;
            if (col >= eff_side(width_reg)) begin
                r.row_done = 1'b1;
                col = 0;
                row++;
                if (row >= eff_side(height_reg)) begin
                    r.frame_done = 1'b1;
                    row = 0;
                    frames++;
                end
                if (rle_on) ph = (bytes_left != 0) ? SKIP_PAD : AWAIT_LEN_LO;
            end
            runs_due.insert(runs_due.size(), r);
        endfunction

        // Notes one accepted input beat and queues the run it causes, if any.
        function void take_beat(t_in_item it);
            int unsigned room;
            int unsigned cnt;
            logic [15:0] rec_len;
            logic [7:0]  b;
            beats++;
            b = it.data_byte;
            if (it.action == ACT_PALETTE) begin
                palette[it.entry_index] = {it.blue, it.green, it.red};
                written[it.entry_index] = 1'b1;
                pal_writes++;
                return;
            end
            if (!rle_on) begin
                if (b == 8'd0) add_run(1, 32'd0, 1'b1);
                else add_run(1, {ALPHA_OPAQUE, palette[b]}, 1'b0);
                return;
            end
            case (ph)
                AWAIT_LEN_LO: begin
                    len_lo = b;
                    ph     = AWAIT_LEN_HI;
                end
                AWAIT_LEN_HI: begin
                    // length counts its own two bytes
                    rec_len    = {b, len_lo};
                    bytes_left = (rec_len >= 16'd2) ? rec_len - 16'd2 : 16'd0;
                    ph         = IN_PIXELS;
                end
                IN_PIXELS: begin
                    if (bytes_left != 0) bytes_left--;
                    if (b == 8'd0) ph = AWAIT_COUNT;
                    else add_run(1, {ALPHA_OPAQUE, palette[b]}, 1'b0);
                end
                AWAIT_COUNT: begin
                    room = eff_side(width_reg) - col;
                    cnt  = b;
                    if (bytes_left != 0) bytes_left--;
                    ph = IN_PIXELS;
                    if (cnt != 0) add_run((cnt < room) ? cnt : room, 32'd0, 1'b1);
                end
                SKIP_PAD: begin
                    if (bytes_left != 0) bytes_left--;
                    if (bytes_left == 0) ph = AWAIT_LEN_LO;
                end
                default: ph = AWAIT_LEN_LO;
            endcase
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_run(t_out_item got);
            t_out_item want;
            runs_seen++;
            if (runs_due.size() == 0) begin
                report($sformatf("run %0d not expected (x %0d y %0d len %0d)",
                                 runs_seen, got.run_x, got.run_y, got.run_length));
                return;
            end
            want = runs_due.pop_front();
            if (got.run_x != want.run_x)
                report($sformatf("run %0d run_x %0d, want %0d",
                                 runs_seen, got.run_x, want.run_x));
            if (got.run_y != want.run_y)
                report($sformatf("run %0d run_y %0d, want %0d",
                                 runs_seen, got.run_y, want.run_y));
            if (got.run_length != want.run_length)
                report($sformatf("run %0d run_length %0d, want %0d",
                                 runs_seen, got.run_length, want.run_length));
            if (got.pixel_color != want.pixel_color)
                report($sformatf("run %0d pixel_color %h, want %h",
                                 runs_seen, got.pixel_color, want.pixel_color));
            if (got.is_transparent != want.is_transparent)
                report($sformatf("run %0d is_transparent %0d, want %0d",
                                 runs_seen, got.is_transparent, want.is_transparent));
            if (got.row_done != want.row_done)
                report($sformatf("run %0d row_done %0d, want %0d",
                                 runs_seen, got.row_done, want.row_done));
            if (got.frame_done != want.frame_done)
                report($sformatf("run %0d frame_done %0d, want %0d",
                                 runs_seen, got.frame_done, want.frame_done));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block hookup. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    t_run_scoreboard board = new();

    bit          steady   = 1'b0;   // no idling on either side while set
    bit          chatter  = 1'b0;   // stray palette writes mixed into the stream
    int unsigned settings = 0;      // register settings gone through

    rle_sprite_palette_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block wedges; far above the slowest clean run.
    initial begin
        #200000;
        $display("rle_sprite_palette_decoder_core_test: FAIL");
        $finish;
    end

    // Result side: sample the pre-edge values, then pick the next ready.
    // Stalls land on about 6 beats in 100, except inside the steady window.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_run(o_out_data);
        i_out_ready <= steady || ($urandom_range(99) >= 6);
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic t_in_item random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    // Valid stays up from one beat to the next unless a gap is taken, so it
    // never drops and rises within the same step.
    task automatic send_beat(t_in_item it);
        while (!steady && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.take_beat(it);
    endtask

    task automatic send_palette(logic [7:0] idx, logic [23:0] bgr);
        t_in_item it;
        it                          = random_item();
        it.action                   = ACT_PALETTE;
        it.entry_index              = idx;
        {it.blue, it.green, it.red} = bgr;
        send_beat(it);
    endtask

    // A pixel that would hit a never-written entry gets that entry filled
    // first; the block's palette is undefined until written.
    task automatic send_byte(logic [7:0] b);
        t_in_item it;
        if (chatter && $urandom_range(99) < 3) send_palette(8'($urandom), 24'($urandom));
        if (board.reads_palette(b) && !board.written[b]) send_palette(b, 24'($urandom));
        it           = random_item();
        it.action    = ACT_SPRITE;
        it.data_byte = b;
        send_beat(it);
    endtask

    task automatic send_bytes(logic [7:0] seq [$]);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Config writes: we stays high across back-to-back writes, caller lowers.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [11:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        board.write_reg(idx, val);
    endtask

    task automatic set_geometry(logic [11:0] w, logic [11:0] h, bit rle,
                                logic [2:0] mask);
        logic [11:0] mode_word;
        mode_word    = 12'($urandom);   // upper bits of the mode word are don't-care
        mode_word[0] = rle;
        if (mask[0]) cfg_write(CFG_FRAME_WIDTH, w);
        if (mask[1]) cfg_write(CFG_FRAME_HEIGHT, h);
        if (mask[2]) cfg_write(CFG_RLE_MODE, mode_word);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // Idle the input, wait for every owed run, then cover the pipeline
    // latency for beats that produce nothing.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.runs_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // One well-formed RLE row record; its length may be exact, long (pad
    // bytes follow the row) or short (including lengths below two).
    task automatic send_record(int unsigned ew);
        logic [7:0]  body [$];
        int unsigned col;
        int unsigned room;
        int unsigned cnt;
        int unsigned pick;
        logic [15:0] rec_len;
        col = 0;
        while (col < ew) begin
            room = ew - col;
            if ($urandom_range(99) < ((ew > 64) ? 90 : 35)) begin
                pick = $urandom_range(99);
                if (pick < 15) cnt = 0;
                else if (pick < 35) cnt = 255;
                else cnt = $urandom_range(1, (room + 2 < 255) ? room + 2 : 255);
                body.insert(body.size(), 8'd0);
                body.insert(body.size(), 8'(cnt));
                col += (cnt < room) ? cnt : room;
            end else begin
                body.insert(body.size(), 8'($urandom_range(1, 255)));
                col++;
            end
        end
        pick = $urandom_range(99);
        if (pick < 60) rec_len = 16'(body.size() + 2);
        else if (pick < 80) rec_len = 16'(body.size() + 2 + $urandom_range(1, 6));
        else if (pick < 88) rec_len = 16'($urandom_range(0, 1));
        else rec_len = 16'($urandom_range(2, body.size() + 1));
        send_byte(rec_len[7:0]);
        send_byte(rec_len[15:8]);
        send_bytes(body);
        for (int i = body.size() + 2; i < rec_len; i++) send_byte(8'($urandom));
    endtask

    // One register setting followed by traffic that suits it.
    task automatic run_phase(logic [11:0] w, logic [11:0] h, bit rle, logic [2:0] mask);
        int unsigned ew;
        int unsigned n;
        logic [7:0]  b;
        drain();
        steady = (board.beats >= 450 && board.beats < 620);
        set_geometry(w, h, rle, mask);
        ew = board.eff_side(board.width_reg);
        if (board.rle_on) begin
            n = (ew > 200) ? $urandom_range(1, 2) : $urandom_range(2, 10);
            for (int i = 0; i < n; i++) begin
                // write to the unused index mid-frame: decode must carry on
                if (i == n / 2 && $urandom_range(99) < 25) begin
                    drain();
                    cfg_write(CFG_UNUSED, 12'($urandom));
                    i_cfg_we <= 1'b0;
                end
                send_record(ew);
            end
            // broken tail: raw bytes, cut off by the next phase's restart
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(3, 15)) send_byte(8'($urandom));
        end else begin
            n = $urandom_range(10, 60);
            repeat (n) begin
                b = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(1, 255));
                send_byte(b);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]  seq [$];
        logic [11:0] w;
        logic [11:0] h;
        int unsigned pick;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, at the reset geometry (64 x 64, RLE).
        send_palette(8'h00, 24'hFFFFFF);
        send_palette(8'hFF, 24'h000000);
        send_palette(8'h5A, 24'h563412);
        // exact record: zero count, then a 255 run clipped to the row
        seq = {8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_bytes(seq);
        // long record: pixel, run to row end, then three skipped bytes
        seq = {8'h08, 8'h00, 8'hFF, 8'h00, 8'h3F, 8'hC3, 8'h00, 8'h7E};
        send_bytes(seq);
        // length below two: row still decodes, nothing skipped afterwards
        seq = {8'h01, 8'h00, 8'h5A, 8'h00, 8'hFF};
        send_bytes(seq);
        // plain mode alone: a zero index is transparent
        drain();
        cfg_write(CFG_RLE_MODE, 12'hFFE);
        i_cfg_we <= 1'b0;
        settings++;
        seq = {8'h00, 8'hFF, 8'h5A};
        send_bytes(seq);

        // Geometry extremes: zero acts as one, oversize clamps to the max.
        chatter = 1'b1;
        run_phase(12'd0,    12'd0,    1'b1, 3'b111);
        run_phase(12'hFFF,  12'd1,    1'b1, 3'b111);
        run_phase(12'd1,    12'hFFF,  1'b0, 3'b111);
        run_phase(12'd2048, 12'hFFF,  1'b1, 3'b111);
        run_phase(12'd3,    12'd2,    1'b1, 3'b111);
        run_phase(12'd5,    12'd3,    1'b0, 3'b111);

        // Random settings, some registers left as they were.
        while (board.beats < 760) begin
            pick = $urandom_range(99);
            if (pick < 8) w = 12'd0;
            else if (pick < 14) w = 12'd1;
            else if (pick < 18) w = 12'hFFF;
            else if (pick < 21) w = 12'd2048;
            else w = 12'($urandom_range(2, 40));
            pick = $urandom_range(99);
            if (pick < 10) h = 12'd0;
            else if (pick < 20) h = 12'd1;
            else if (pick < 28) h = 12'hFFF;
            else h = 12'($urandom_range(1, 8));
            run_phase(w, h, $urandom_range(99) < 70, 3'($urandom_range(1, 7)));
        end

        steady = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);
        if (board.runs_due.size() != 0)
            board.report($sformatf("%0d runs never arrived", board.runs_due.size()));

        $display("covered %0d input beats (%0d palette writes) over %0d register settings",
                 board.beats, board.pal_writes, settings);
        $display("checked %0d pixel runs, %0d frame ends; %0d mismatches",
                 board.runs_seen, board.frames, board.errors);
        if (board.errors == 0) begin
            $display("rle_sprite_palette_decoder_core_test: PASS");
        end else begin
            $display("rle_sprite_palette_decoder_core_test: FAIL");
        end
        $finish;
    end

endmodule

// File: rle_sprite_palette_decoder_core.f
+incdir+sv
sv/rspd_pkg.sv
sv/rspd_palette_ram.sv
sv/rspd_decode.sv
sv/rspd_out_buf.sv
sv/rle_sprite_palette_decoder_core.sv
test/rle_sprite_palette_decoder_core_test.sv
